>>> hdl/radix2_complex_fft_unit_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the radix-2 FFT unit
// Shorthand for clocked implication checks, gated by the reset.
// ----------------------------------------------------------------------------
`ifndef RADIX2_COMPLEX_FFT_UNIT_MACROS_SVH
`define RADIX2_COMPLEX_FFT_UNIT_MACROS_SVH

// same-cycle implication
`define R2F_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define R2F_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> hdl/r2fft_pkg.sv
// ----------------------------------------------------------------------------
// r2fft_pkg
// Shared constants, types, twiddle tables and helper functions of the FFT unit.
// ----------------------------------------------------------------------------
package r2fft_pkg;

    localparam int MAX_LOG2   = 10;
    localparam int MAX_POINTS = 1 << MAX_LOG2;
    localparam int QUARTER    = MAX_POINTS / 4;
    localparam int SMP_W      = 16;
    localparam int TW_W       = 16;
    localparam int TW_FRAC    = TW_W - 1;
    localparam int RES_W      = SMP_W + MAX_LOG2 + 1;
    localparam int WORD_W     = 2 * RES_W;
    localparam int AW         = MAX_LOG2;
    localparam int PROD_W     = RES_W + TW_W + 1;
    localparam int ACC_W      = PROD_W + 1;
    localparam int PR_W       = ACC_W - TW_FRAC;
    localparam int SUM_W      = PR_W + 1;

    localparam longint ONE_Q30     = 64'sd1 << 30;
    localparam longint HALF_PI_Q30 = 64'sd1686629713;

    // Taylor term divisors: (2n-1)(2n) for cosine, (2n)(2n+1) for sine
    localparam longint unsigned COS_TERM_DIV [1:10] =
        '{64'd2, 64'd12, 64'd30, 64'd56, 64'd90, 64'd132, 64'd182, 64'd240, 64'd306, 64'd380};
    localparam longint unsigned SIN_TERM_DIV [1:10] =
        '{64'd6, 64'd20, 64'd42, 64'd72, 64'd110, 64'd156, 64'd210, 64'd272, 64'd342, 64'd420};

    typedef enum logic [0:0] {
        REG_LOG2_LENGTH = 1'b0,
        REG_INVERSE     = 1'b1
    } cfg_reg_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_RDOUT,
        S_BFRD,
        S_MUL,
        S_SUM,
        S_WA,
        S_WB
    } state_t;

    typedef logic [TW_W-2:0] tw_rom_t [0:QUARTER];

    // store write request
    typedef struct packed {
        logic              we;
        logic [AW-1:0]     addr;
        logic [WORD_W-1:0] data;
    } mem_wr_t;

    // round a Q30 value to Q1.15 with the top clipped below 1.0
    function automatic logic [TW_W-2:0] quantize(input longint q30);
        longint r;
        begin
            r = (q30 + (64'sd1 <<< (29 - TW_FRAC))) >>> (30 - TW_FRAC);
            if (r > (64'sd1 <<< TW_FRAC) - 1)
                r = (64'sd1 <<< TW_FRAC) - 1;
            quantize = r[TW_W-2:0];
        end
    endfunction

    // quarter-wave cosine or sine table from a Taylor series in Q30
    function automatic tw_rom_t build_rom(input bit want_sin);
        tw_rom_t          rom;
        longint unsigned  x;
        longint unsigned  x2;
        longint unsigned  tc;
        longint unsigned  ts;
        longint           c;
        longint           s;
        begin
            for (int j = 0; j <= QUARTER; j++) begin
                x  = (longint'(j) * HALF_PI_Q30 + QUARTER / 2) >> (MAX_LOG2 - 2);
                x2 = (x * x) >> 30;
                tc = ONE_Q30;
                ts = x;
                c  = ONE_Q30;
                s  = longint'(x);
                for (int n = 1; n <= 10; n++) begin
                    tc = ((tc * x2) >> 30) / COS_TERM_DIV[n];
                    ts = ((ts * x2) >> 30) / SIN_TERM_DIV[n];
                    if ((n & 1) == 1) begin
                        c = c - longint'(tc);
                        s = s - longint'(ts);
                    end else begin
                        c = c + longint'(tc);
                        s = s + longint'(ts);
                    end
                end
                if (c < 0) c = 0;
                if (c > ONE_Q30) c = ONE_Q30;
                if (s < 0) s = 0;
                if (s > ONE_Q30) s = ONE_Q30;
                rom[j] = want_sin ? quantize(s) : quantize(c);
            end
            build_rom = rom;
        end
    endfunction

    localparam tw_rom_t COS_ROM = build_rom(1'b0);
    localparam tw_rom_t SIN_ROM = build_rom(1'b1);

    // clip a butterfly sum to the result width
    function automatic logic [RES_W-1:0] sat_res(input logic signed [SUM_W-1:0] v);
        logic signed [SUM_W-1:0] lim;
        begin
            lim = SUM_W'(1) <<< (RES_W - 1);
            if (v < -lim)
                sat_res = {1'b1, {(RES_W-1){1'b0}}};
            else if (v > lim - $signed(SUM_W'(1)))
                sat_res = {1'b0, {(RES_W-1){1'b1}}};
            else
                sat_res = v[RES_W-1:0];
        end
    endfunction

    // bit-reverse the low l bits of an index
    function automatic logic [AW-1:0] bit_rev(input logic [AW-1:0] idx,
                                              input logic [3:0] l);
        logic [AW-1:0] r;
        begin
            for (int b = 0; b < AW; b++)
                r[AW-1-b] = idx[b];
            bit_rev = r >> (4'(AW) - l);
        end
    endfunction

endpackage

>>> hdl/radix2_complex_fft_unit.sv
// ----------------------------------------------------------------------------
// radix2_complex_fft_unit
// Radix-2 decimation-in-time complex FFT with a single shared multiplier.
// ----------------------------------------------------------------------------
// A load (func 0) lands in bit-reversed order in the store; the N-th load
// starts the transform and busy stays high until it ends. Each butterfly is
// two reads, four products through one 27x17 multiplier, a rounding step and
// two writes on the single store write port. A read (func 1) is taken when
// results are ready, holds busy and gives the bin on the result ports with
// strobe high for one cycle, after the registered store read and the result
// registers; the receiver must take it then. Reads with no results ready are
// dropped. A register write resets the counts and ready but does not stop a
// transform in progress; it must only be made while busy is low.
// ----------------------------------------------------------------------------
`include "radix2_complex_fft_unit_macros.svh"

module radix2_complex_fft_unit (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  cfg_we,
    input  logic [0:0]                            cfg_index,
    input  logic [3:0]                            cfg_data,
    input  logic                                  start,
    output logic                                  busy,
    input  logic                                  func,
    input  logic signed [r2fft_pkg::SMP_W-1:0]    sample_re,
    input  logic signed [r2fft_pkg::SMP_W-1:0]    sample_im,
    output logic                                  strobe,
    output logic signed [r2fft_pkg::RES_W-1:0]    bin_re,
    output logic signed [r2fft_pkg::RES_W-1:0]    bin_im,
    output logic [r2fft_pkg::AW-1:0]              bin_index,
    output logic                                  last_bin
);
    import r2fft_pkg::*;

    state_t              state_reg, state_next;
    logic [3:0]          log2_reg;
    logic                inv_reg;
    logic [AW-1:0]       load_cnt_reg;
    logic [AW-1:0]       read_cnt_reg;
    logic                ready_reg;
    logic [3:0]          stage_reg;
    logic [AW-2:0]       bf_reg;
    logic [2:0]          ph_reg;
    logic [AW-1:0]       rk_reg;
    logic signed [PROD_W-1:0] prod_reg;
    logic signed [ACC_W-1:0]  accr_reg, acci_reg;
    logic signed [PR_W-1:0]   pr_reg, pi_reg;
    logic                strobe_reg;
    logic [RES_W-1:0]    bin_re_reg, bin_im_reg;
    logic [AW-1:0]       bin_index_reg;
    logic                last_reg;

    logic [3:0]          eff_l;
    logic [AW:0]         n_pts;
    logic [AW-1:0]       nmask;
    logic                acc_load, acc_read, transform_done;
    logic [AW-1:0]       k_idx, src_idx, ia, ib, hspan, bf_ext;
    logic [AW-2:0]       tw_m, tw_mm;
    logic [AW-2:0]       tw_idx;
    logic signed [TW_W:0] cos_v, sin_v;
    logic signed [RES_W-1:0] ar, ai, br, bi, op_a;
    logic signed [TW_W:0]    op_b;
    logic                bf_last, stage_last;
    logic [WORD_W-1:0]   rdata_a, rdata_b;
    logic                rd_en;
    mem_wr_t             mem_wr;
    logic signed [RES_W:0] sh_re, sh_im;

    // effective length
    always_comb
    begin
        if (log2_reg == 4'd0)
            eff_l = 4'd1;
        else if (log2_reg > 4'(MAX_LOG2))
            eff_l = 4'(MAX_LOG2);
        else
            eff_l = log2_reg;
    end

    assign n_pts    = (AW+1)'(1) << eff_l;
    assign nmask    = AW'(n_pts - (AW+1)'(1));
    assign busy     = (state_reg != S_IDLE);
    assign acc_load = start && !busy && !func;
    assign acc_read = start && !busy && func && ready_reg;
    assign k_idx    = read_cnt_reg & nmask;
    assign src_idx  = inv_reg ? ((AW'(n_pts) - k_idx) & nmask) : k_idx;

    // butterfly addressing: insert a zero bit at the stage position
    assign hspan      = AW'(1) << stage_reg;
    assign bf_ext     = {1'b0, bf_reg};
    assign ia         = ((bf_ext & ~(hspan - AW'(1))) << 1) | (bf_ext & (hspan - AW'(1)));
    assign ib         = ia | hspan;
    assign tw_m       = (AW-1)'((bf_ext & (hspan - AW'(1))) << (4'(AW-1) - stage_reg));
    assign bf_last    = (bf_ext == AW'((n_pts >> 1) - (AW+1)'(1)));
    assign stage_last = (stage_reg == eff_l - 4'd1);
    assign transform_done = (state_reg == S_WB) && bf_last && stage_last;

    // twiddle lookup, second quadrant by symmetry
    assign tw_mm  = (AW-1)'(MAX_POINTS / 2) - tw_m;
    assign tw_idx = (tw_m <= (AW-1)'(QUARTER)) ? tw_m : tw_mm;
    always_comb
    begin
        sin_v = $signed({2'b00, SIN_ROM[tw_idx]});
        if (tw_m <= (AW-1)'(QUARTER))
            cos_v = $signed({2'b00, COS_ROM[tw_idx]});
        else
            cos_v = -$signed({2'b00, COS_ROM[tw_idx]});
    end

    assign ar = $signed(rdata_a[WORD_W-1:RES_W]);
    assign ai = $signed(rdata_a[RES_W-1:0]);
    assign br = $signed(rdata_b[WORD_W-1:RES_W]);
    assign bi = $signed(rdata_b[RES_W-1:0]);

    // multiplier operand select per phase
    always_comb
    begin
        case (ph_reg)
            3'd0:    begin op_a = br; op_b = cos_v;  end
            3'd1:    begin op_a = bi; op_b = sin_v;  end
            3'd2:    begin op_a = bi; op_b = cos_v;  end
            3'd3:    begin op_a = br; op_b = -sin_v; end
            default: begin op_a = br; op_b = cos_v;  end
        endcase
    end

    // store ports
    assign rd_en = acc_read || (state_reg == S_BFRD);
    always_comb
    begin
        mem_wr.we   = 1'b0;
        mem_wr.addr = ia;
        mem_wr.data = {sat_res(SUM_W'(ar) + SUM_W'(pr_reg)),
                       sat_res(SUM_W'(ai) + SUM_W'(pi_reg))};
        if (acc_load)
        begin
            mem_wr.we   = 1'b1;
            mem_wr.addr = bit_rev(load_cnt_reg, eff_l);
            mem_wr.data = {RES_W'(sample_re), RES_W'(sample_im)};
        end
        else if (state_reg == S_WA)
            mem_wr.we = 1'b1;
        else if (state_reg == S_WB)
        begin
            mem_wr.we   = 1'b1;
            mem_wr.addr = ib;
            mem_wr.data = {sat_res(SUM_W'(ar) - SUM_W'(pr_reg)),
                           sat_res(SUM_W'(ai) - SUM_W'(pi_reg))};
        end
    end

    r2fft_mem u_mem (
        .clk     (clk),
        .wr      (mem_wr),
        .rd_en   (rd_en),
        .raddr_a ((state_reg == S_IDLE) ? src_idx : ia),
        .raddr_b (ib),
        .rdata_a (rdata_a),
        .rdata_b (rdata_b)
    );

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (acc_read)
                    state_next = S_RDOUT;
                else if (acc_load && ({1'b0, load_cnt_reg} + (AW+1)'(1) >= n_pts))
                    state_next = S_BFRD;
            end
            S_RDOUT: state_next = S_IDLE;
            S_BFRD:  state_next = S_MUL;
            S_MUL:   state_next = (ph_reg == 3'd4) ? S_SUM : S_MUL;
            S_SUM:   state_next = S_WA;
            S_WA:    state_next = S_WB;
            S_WB:    state_next = transform_done ? S_IDLE : S_BFRD;
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= S_IDLE;
        else
            state_reg <= state_next;
    end

    // control counters and registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            log2_reg     <= 4'd10;
            inv_reg      <= 1'b0;
            load_cnt_reg <= '0;
            read_cnt_reg <= '0;
            ready_reg    <= 1'b0;
            stage_reg    <= '0;
            bf_reg       <= '0;
            ph_reg       <= '0;
            strobe_reg   <= 1'b0;
        end
        else
        begin
            strobe_reg <= (state_reg == S_RDOUT);
            if (cfg_we)
            begin
                case (cfg_index)
                    REG_LOG2_LENGTH: log2_reg <= cfg_data;
                    REG_INVERSE:     inv_reg  <= cfg_data[0];
                    default:         log2_reg <= log2_reg;
                endcase
                load_cnt_reg <= '0;
                read_cnt_reg <= '0;
                ready_reg    <= 1'b0;
            end
            else if (acc_load)
            begin
                ready_reg    <= 1'b0;
                read_cnt_reg <= '0;
                stage_reg    <= '0;
                bf_reg       <= '0;
                if ({1'b0, load_cnt_reg} + (AW+1)'(1) >= n_pts)
                    load_cnt_reg <= '0;
                else
                    load_cnt_reg <= load_cnt_reg + AW'(1);
            end
            else if (acc_read)
            begin
                if (k_idx == nmask)
                begin
                    ready_reg    <= 1'b0;
                    read_cnt_reg <= '0;
                end
                else
                    read_cnt_reg <= k_idx + AW'(1);
            end
            // advance the butterfly sequencer
            if (state_reg == S_BFRD)
                ph_reg <= '0;
            else if (state_reg == S_MUL)
                ph_reg <= ph_reg + 3'd1;
            if (state_reg == S_WB)
            begin
                if (bf_last)
                begin
                    bf_reg <= '0;
                    if (stage_last)
                        ready_reg <= 1'b1;
                    else
                        stage_reg <= stage_reg + 4'd1;
                end
                else
                    bf_reg <= bf_reg + (AW-1)'(1);
            end
        end
    end

    // multiply and accumulate
    always_ff @(posedge clk)
    begin
        if (state_reg == S_MUL)
        begin
            prod_reg <= op_a * op_b;
            case (ph_reg)
                3'd1:    accr_reg <= ACC_W'(prod_reg);
                3'd2:    accr_reg <= accr_reg + ACC_W'(prod_reg);
                3'd3:    acci_reg <= ACC_W'(prod_reg);
                3'd4:    acci_reg <= acci_reg + ACC_W'(prod_reg);
                default: accr_reg <= accr_reg;
            endcase
        end
        // round once, bypass for the zero-angle twiddle
        if (state_reg == S_SUM)
        begin
            if (tw_m == '0)
            begin
                pr_reg <= PR_W'(br);
                pi_reg <= PR_W'(bi);
            end
            else
            begin
                pr_reg <= PR_W'((accr_reg + $signed(ACC_W'(1) << (TW_FRAC - 1))) >>> TW_FRAC);
                pi_reg <= PR_W'((acci_reg + $signed(ACC_W'(1) << (TW_FRAC - 1))) >>> TW_FRAC);
            end
        end
    end

    // result stage: mirror is in the address, scale by 1/N here for the inverse
    assign sh_re = (($signed({ar[RES_W-1], ar}) + $signed((RES_W+1)'(1) << (eff_l - 4'd1)))
                    >>> eff_l);
    assign sh_im = (($signed({ai[RES_W-1], ai}) + $signed((RES_W+1)'(1) << (eff_l - 4'd1)))
                    >>> eff_l);

    always_ff @(posedge clk)
    begin
        if (acc_read)
            rk_reg <= k_idx;
        if (state_reg == S_RDOUT)
        begin
            bin_re_reg    <= inv_reg ? RES_W'(sh_re) : ar;
            bin_im_reg    <= inv_reg ? RES_W'(sh_im) : ai;
            bin_index_reg <= rk_reg;
            last_reg      <= (rk_reg == nmask);
        end
    end

    assign strobe    = strobe_reg;
    assign bin_re    = bin_re_reg;
    assign bin_im    = bin_im_reg;
    assign bin_index = bin_index_reg;
    assign last_bin  = last_reg;

    `R2F_ASSERT_NEXT(a_rd_strobe, state_reg == S_RDOUT, strobe, "read did not strobe")
    `R2F_ASSERT_NEXT(a_done_ready, transform_done && !cfg_we, ready_reg,
                     "transform end did not raise ready")
    `R2F_ASSERT_NEXT(a_last_clears, acc_read && (k_idx == nmask) && !cfg_we, !ready_reg,
                     "last bin did not clear ready")
    `R2F_ASSERT_NOW(a_mul_phase, state_reg == S_MUL, ph_reg <= 3'd4, "multiply phase overrun")

endmodule

>>> hdl/r2fft_mem.sv
// ----------------------------------------------------------------------------
// r2fft_mem
// Sample store: one write port, two registered read ports.
// ----------------------------------------------------------------------------
module r2fft_mem (
    input  logic                      clk,
    input  r2fft_pkg::mem_wr_t        wr,
    input  logic                      rd_en,
    input  logic [r2fft_pkg::AW-1:0]  raddr_a,
    input  logic [r2fft_pkg::AW-1:0]  raddr_b,
    output logic [r2fft_pkg::WORD_W-1:0] rdata_a,
    output logic [r2fft_pkg::WORD_W-1:0] rdata_b
);
    import r2fft_pkg::*;

    logic [WORD_W-1:0] mem [0:MAX_POINTS-1];

    // write port
    always_ff @(posedge clk)
    begin
        if (wr.we)
            mem[wr.addr] <= wr.data;
    end

    // read both ports, hold when idle
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rdata_a <= mem[raddr_a];
            rdata_b <= mem[raddr_b];
        end
    end

endmodule

>>> test/fft_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// FFT bin checker
// Watches the register port, the item transfers and the result strobe of the
// radix-2 FFT unit, predicts every bin with its own fixed-point transform and
// compares each bin with the oldest prediction still outstanding.
// ----------------------------------------------------------------------------
module fft_checker
    import r2fft_pkg::*;
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    cfg_we,
    input  logic [0:0]              cfg_index,
    input  logic [3:0]              cfg_data,
    input  logic                    start,
    input  logic                    busy,
    input  logic                    func,
    input  logic signed [SMP_W-1:0] sample_re,
    input  logic signed [SMP_W-1:0] sample_im,
    input  logic                    strobe,
    input  logic signed [RES_W-1:0] bin_re,
    input  logic signed [RES_W-1:0] bin_im,
    input  logic [AW-1:0]           bin_index,
    input  logic                    last_bin,
    output int                      errors,
    output int                      pending
);

    localparam logic FUNC_LOAD = 1'b0;

    typedef struct {
        logic [RES_W-1:0] re;
        logic [RES_W-1:0] im;
        logic [AW-1:0]    idx;
        logic             last;
    } fft_bin_t;

    fft_bin_t    bins_due[$];
    longint      spec_re[MAX_POINTS];
    longint      spec_im[MAX_POINTS];
    longint      cos_tab[QUARTER+1];
    longint      sin_tab[QUARTER+1];
    logic [3:0]  len_code;
    logic        inv_mode;
    int unsigned loads_seen;
    int unsigned reads_done;
    bit          bins_ready;

    assign pending = bins_due.size();

    // clip a butterfly output to the result width
    function automatic longint clip_res(input longint v);
        longint lim;
        begin
            lim = longint'(1) <<< (RES_W - 1);
            if (v < -lim) return -lim;
            if (v > lim - 1) return lim - 1;
            return v;
        end
    endfunction

    // Q30 to Q1.15, half up, held below 1.0
    function automatic longint to_q15(input longint q30);
        longint r;
        begin
            r = (q30 + (longint'(1) <<< (29 - TW_FRAC))) >>> (30 - TW_FRAC);
            if (r > (longint'(1) <<< TW_FRAC) - 1) r = (longint'(1) <<< TW_FRAC) - 1;
            return r;
        end
    endfunction

    // quarter-wave twiddles from a Taylor series in Q30
    function automatic void make_twiddles();
        longint unsigned ang;
        longint unsigned ang_sq;
        longint unsigned term_c;
        longint unsigned term_s;
        longint          acc_c;
        longint          acc_s;
        begin
            for (int j = 0; j <= QUARTER; j++) begin
                ang    = (longint'(j) * 64'd1686629713 + QUARTER / 2) / QUARTER;
                ang_sq = (ang * ang) >> 30;
                term_c = 64'd1 << 30;
                term_s = ang;
                acc_c  = 64'sd1 << 30;
                acc_s  = longint'(ang);
                for (int n = 1; n <= 10; n++) begin
                    term_c = ((term_c * ang_sq) >> 30) / longint'((2*n - 1) * (2*n));
                    term_s = ((term_s * ang_sq) >> 30) / longint'((2*n) * (2*n + 1));
                    if (n % 2 == 1) begin
                        acc_c -= longint'(term_c);
                        acc_s -= longint'(term_s);
                    end
                    else begin
                        acc_c += longint'(term_c);
                        acc_s += longint'(term_s);
                    end
                end
                if (acc_c < 0) acc_c = 0;
                if (acc_c > (64'sd1 << 30)) acc_c = 64'sd1 << 30;
                if (acc_s < 0) acc_s = 0;
                if (acc_s > (64'sd1 << 30)) acc_s = 64'sd1 << 30;
                cos_tab[j] = to_q15(acc_c);
                sin_tab[j] = to_q15(acc_s);
            end
        end
    endfunction

    function automatic int unsigned eff_log2();
        if (len_code < 1) return 1;
        if (len_code > MAX_LOG2) return MAX_LOG2;
        return len_code;
    endfunction

    // in-place decimation-in-time transform over the first 2^l entries
    function automatic void run_fft(input int unsigned l);
        int unsigned npts;
        int unsigned rev;
        int unsigned step;
        int unsigned tw;
        int unsigned ia;
        int unsigned ib;
        longint      tmp;
        longint      c;
        longint      s;
        longint      pr;
        longint      pi;
        longint      ar;
        longint      ai;
        longint      br;
        longint      bi;
        begin
            npts = 1 << l;
            for (int unsigned i = 0; i < npts; i++) begin
                rev = 0;
                for (int unsigned b = 0; b < l; b++)
                    rev |= ((i >> b) & 1) << (l - 1 - b);
                if (rev > i) begin
                    tmp = spec_re[i]; spec_re[i] = spec_re[rev]; spec_re[rev] = tmp;
                    tmp = spec_im[i]; spec_im[i] = spec_im[rev]; spec_im[rev] = tmp;
                end
            end
            for (int unsigned h = 1; h < npts; h <<= 1) begin
                step = (MAX_POINTS / npts) * (npts / (2 * h));
                for (int unsigned g = 0; g < npts; g += 2 * h) begin
                    for (int unsigned j = 0; j < h; j++) begin
                        tw = j * step;
                        ia = g + j;
                        ib = ia + h;
                        ar = spec_re[ia]; ai = spec_im[ia];
                        br = spec_re[ib]; bi = spec_im[ib];
                        if (tw == 0) begin
                            pr = br;
                            pi = bi;
                        end
                        else begin
                            if (tw <= QUARTER) begin
                                c = cos_tab[tw];
                                s = sin_tab[tw];
                            end
                            else begin
                                c = -cos_tab[MAX_POINTS/2 - tw];
                                s = sin_tab[MAX_POINTS/2 - tw];
                            end
                            pr = (br * c + bi * s + (longint'(1) <<< (TW_FRAC - 1))) >>> TW_FRAC;
                            pi = (bi * c - br * s + (longint'(1) <<< (TW_FRAC - 1))) >>> TW_FRAC;
                        end
                        spec_re[ia] = clip_res(ar + pr);
                        spec_im[ia] = clip_res(ai + pi);
                        spec_re[ib] = clip_res(ar - pr);
                        spec_im[ib] = clip_res(ai - pi);
                    end
                end
            end
        end
    endfunction

    // advance the prediction by one transferred item
    function automatic void take_item(input logic f, input logic signed [SMP_W-1:0] re,
                                      input logic signed [SMP_W-1:0] im);
        int unsigned l;
        int unsigned npts;
        int unsigned k;
        int unsigned src;
        longint      vr;
        longint      vi;
        fft_bin_t    b;
        begin
            l    = eff_log2();
            npts = 1 << l;
            if (f == FUNC_LOAD) begin
                if (bins_ready) begin
                    bins_ready = 0;
                    reads_done = 0;
                end
                spec_re[loads_seen % MAX_POINTS] = re;
                spec_im[loads_seen % MAX_POINTS] = im;
                loads_seen++;
                if (loads_seen >= npts) begin
                    run_fft(l);
                    loads_seen = 0;
                    bins_ready = 1;
                end
            end
            else if (bins_ready) begin
                k   = reads_done % npts;
                src = inv_mode ? (npts - k) % npts : k;
                vr  = spec_re[src];
                vi  = spec_im[src];
                if (inv_mode) begin
                    vr = (vr + (longint'(1) <<< (l - 1))) >>> l;
                    vi = (vi + (longint'(1) <<< (l - 1))) >>> l;
                end
                b.re   = vr[RES_W-1:0];
                b.im   = vi[RES_W-1:0];
                b.idx  = k[AW-1:0];
                b.last = (k == npts - 1);
                bins_due.push_back(b);
                reads_done = k + 1;
                if (b.last) begin
                    bins_ready = 0;
                    reads_done = 0;
                end
            end
        end
    endfunction

    initial make_twiddles();

    // track registers and transfers, compare bins as they appear
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            len_code   <= 4'd10;
            inv_mode   <= 1'b0;
            loads_seen = 0;
            reads_done = 0;
            bins_ready = 0;
            errors     <= 0;
            bins_due.delete();
        end
        else begin
            if (cfg_we) begin
                if (cfg_index == REG_LOG2_LENGTH)
                    len_code <= cfg_data;
                else if (cfg_index == REG_INVERSE)
                    inv_mode <= cfg_data[0];
                loads_seen = 0;
                reads_done = 0;
                bins_ready = 0;
            end
            if (start && !busy)
                take_item(func, sample_re, sample_im);
            if (strobe) begin
                if (bins_due.size() == 0) begin
                    if (errors < 10)
                        $display("ERROR: unexpected bin %0d re %0d im %0d", bin_index,
                                 bin_re, bin_im);
                    errors <= errors + 1;
                end
                else begin
                    fft_bin_t e;
                    e = bins_due.pop_front();
                    if (e.re !== bin_re || e.im !== bin_im || e.idx !== bin_index
                        || e.last !== last_bin) begin
                        if (errors < 10)
                            $display("ERROR: bin exp idx %0d re %0d im %0d last %0b, got idx %0d re %0d im %0d last %0b",
                                     e.idx, $signed(e.re), $signed(e.im), e.last,
                                     bin_index, bin_re, bin_im, last_bin);
                        errors <= errors + 1;
                    end
                end
            end
        end
    end

endmodule

>>> test/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// FFT unit testbench top
// Drives loads, reads and register writes into the radix-2 FFT unit in
// random bursts and leaves prediction and comparison to the bin checker.
// ----------------------------------------------------------------------------
module tb_top;
    import r2fft_pkg::*;

    localparam logic FUNC_LOAD  = 1'b0;
    localparam logic FUNC_READ  = 1'b1;
    localparam int   CYCLE_CAP  = 3000000;
    localparam int   ITEM_GOAL  = 1900;

    logic                    clk;
    logic                    rst_n;
    logic                    cfg_we;
    logic [0:0]              cfg_index;
    logic [3:0]              cfg_data;
    logic                    start;
    logic                    busy;
    logic                    func;
    logic signed [SMP_W-1:0] sample_re;
    logic signed [SMP_W-1:0] sample_im;
    logic                    strobe;
    logic signed [RES_W-1:0] bin_re;
    logic signed [RES_W-1:0] bin_im;
    logic [AW-1:0]           bin_index;
    logic                    last_bin;
    int                      errors;
    int                      pending;
    int                      cycles;
    int                      burst_left;
    int                      sent;

    radix2_complex_fft_unit dut (.*);
    fft_checker chk (.*);

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // give up on a hung run
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_CAP) begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    function automatic logic signed [SMP_W-1:0] pick_sample();
        case ($urandom_range(0, 7))
            0: return 16'sh7fff;
            1: return 16'sh8000;
            2: return 16'sd0;
            default: return 16'($urandom());
        endcase
    endfunction

    // one transfer; hold between bursts
    task automatic transfer(input logic f, input logic signed [SMP_W-1:0] re,
                            input logic signed [SMP_W-1:0] im);
        begin
            if (burst_left == 0) begin
                start = 1'b0;
                repeat ($urandom_range(1, 7)) @(negedge clk);
                burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(30, 80)
                                                         : $urandom_range(1, 12);
            end
            burst_left--;
            start     = 1'b0;
            while (busy) @(negedge clk);
            start     = 1'b1;
            func      = f;
            sample_re = re;
            sample_im = im;
            @(negedge clk);
            start     = 1'b0;
            sent++;
        end
    endtask

    // write a register once everything outstanding has drained
    task automatic write_reg(input cfg_reg_t idx, input logic [3:0] val);
        begin
            while (busy || pending != 0) @(negedge clk);
            repeat (4) @(negedge clk);
            cfg_we    = 1'b1;
            cfg_index = idx;
            cfg_data  = val;
            @(negedge clk);
            cfg_we    = 1'b0;
        end
    endtask

    task automatic load_random(input int count);
        for (int i = 0; i < count; i++)
            transfer(FUNC_LOAD, pick_sample(), pick_sample());
    endtask

    task automatic read_bins(input int count);
        for (int i = 0; i < count; i++)
            transfer(FUNC_READ, pick_sample(), pick_sample());
    endtask

    initial
    begin
        int npts;
        int lval;
        rst_n      = 1'b0;
        cfg_we     = 1'b0;
        cfg_index  = REG_LOG2_LENGTH;
        cfg_data   = 4'd0;
        start      = 1'b0;
        func       = FUNC_LOAD;
        sample_re  = '0;
        sample_im  = '0;
        cycles     = 0;
        burst_left = 0;
        sent       = 0;
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // read before any transform: dropped
        read_bins(1);
        // abort a partial load at reset length, then shortest forward
        load_random(3);
        write_reg(REG_LOG2_LENGTH, 4'd1);
        transfer(FUNC_LOAD, 16'sh7fff, 16'sh8000);
        transfer(FUNC_LOAD, 16'sh8000, 16'sh7fff);
        read_bins(3);
        // inverse, cut short by a new load
        write_reg(REG_INVERSE, 4'd1);
        transfer(FUNC_LOAD, 16'sh7fff, 16'sh7fff);
        transfer(FUNC_LOAD, 16'sh8000, 16'sh8000);
        read_bins(1);
        load_random(2);
        read_bins(2);
        // length code zero acts as one
        write_reg(REG_LOG2_LENGTH, 4'd0);
        load_random(2);
        read_bins(2);
        // length code above range acts as full size, inverse; read the first bins
        write_reg(REG_LOG2_LENGTH, 4'd15);
        load_random(MAX_POINTS);
        read_bins(64);
        write_reg(REG_LOG2_LENGTH, 4'd10);
        write_reg(REG_INVERSE, 4'd0);
        load_random(5);

        // random phases at small lengths
        while (sent < ITEM_GOAL) begin
            lval = $urandom_range(0, 6);
            write_reg(REG_LOG2_LENGTH, lval[3:0]);
            if ($urandom_range(0, 2) == 0)
                write_reg(REG_INVERSE, 4'($urandom_range(0, 1)));
            npts = 1 << ((lval < 1) ? 1 : lval);
            case ($urandom_range(0, 9))
                7: begin
                    load_random(npts);
                    read_bins($urandom_range(1, npts));
                    load_random(npts);
                    read_bins(npts);
                end
                8: begin
                    read_bins($urandom_range(1, 3));
                    load_random(npts);
                    read_bins(npts + $urandom_range(1, 3));
                end
                9: load_random($urandom_range(1, npts - 1));
                default: begin
                    load_random(npts);
                    read_bins(npts);
                end
            endcase
        end

        // drain
        while (busy || pending != 0) @(negedge clk);
        repeat (20) @(negedge clk);
        if (errors == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule

>>> radix2_complex_fft_unit.f
+incdir+hdl
hdl/r2fft_pkg.sv
hdl/r2fft_mem.sv
hdl/radix2_complex_fft_unit.sv
test/fft_checker.sv
test/tb_top.sv
